// ===== sv/rdp_pkg.sv =====
// Shared types and constants for the RDP polyline simplifier.
`default_nettype none
package rdp_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Word moved from the loader to the simplifier.
    typedef struct packed {
        logic             is_point;   // store a point
        logic [IDX_W-1:0] slot;
        logic [15:0]      x;
        logic [15:0]      y;
        logic             end_line;   // run the simplifier after this word
        logic [CNT_W-1:0] count;      // points stored, valid with end_line
        logic             overflow;
    } rdp_cmd_t;
endpackage : rdp_pkg
`default_nettype wire

// ===== sv/polyline_simplify_rdp_unit.sv =====
// Top level of the Ramer-Douglas-Peucker polyline simplifier.
//
//  channel | signals                                 | dir
//  in      | in_valid/in_ready, point_x/y, end_of_line| in
//  out     | out_valid/out_ready, kept_x/y, last_kept,| out
//          | status                                  |
//  apb     | psel penable pwrite paddr pwdata prdata | in/out
//
// Points load one a cycle, while the queue has room, into a 64-entry point
// memory via a two-word queue. After the end-of-line word the simplifier pops
// segments and scans each from memory, one point a cycle. Output walks all
// stored points, stalling on out_ready. Reset clears counts and stack; keep
// marks are cleared as each point is stored and the point memory is not
// cleared. The loader stalls while the queue is full.
`default_nettype none
module polyline_simplify_rdp_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] point_x,
    input  wire logic [15:0] point_y,
    input  wire logic        end_of_line,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      kept_x,
    output logic [15:0]      kept_y,
    output logic             last_kept,
    output logic [1:0]       status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rdp_pkg::*;
    logic [15:0] tol_reg;
    rdp_cmd_t    f_cmd, q_cmd;
    logic        f_valid, f_ready, q_valid, q_ready;

    // only register 0 (tolerance) exists; address 1 reads as zero
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, tol_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            tol_reg <= pwdata[15:0];
    end

    rdp_front u_front (
        .clk, .rst_n, .in_valid, .in_ready,
        .x(point_x), .y(point_y), .eol(end_of_line),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );
    rdp_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );
    rdp_back u_back (
        .clk, .rst_n, .tolerance(tol_reg),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid, .out_ready, .kept_x, .kept_y, .last_kept, .status
    );
endmodule : polyline_simplify_rdp_unit
`default_nettype wire

// ===== sv/rdp_front.sv =====
// Input side: counts points, flags overflow, issues store/end commands.
`default_nettype none
module rdp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [15:0]      x,
    input  wire logic [15:0]      y,
    input  wire logic             eol,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output rdp_pkg::rdp_cmd_t     cmd
);
    import rdp_pkg::*;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             room;

    assign room      = (count_reg < CNT_W'(MAX_POINTS));
    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_comb
    begin
        cmd.is_point = room;
        cmd.slot     = count_reg[IDX_W-1:0];
        cmd.x        = x;
        cmd.y        = y;
        cmd.end_line = eol;
        cmd.count    = room ? count_reg + 1'b1 : count_reg;
        cmd.overflow = ovf_reg | ~room;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        if (in_valid && cmd_ready)
        begin
            if (eol)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = cmd.count;
                ovf_next   = cmd.overflow;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule : rdp_front
`default_nettype wire

// ===== sv/rdp_queue.sv =====
// Short command queue between loader and simplifier.
`default_nettype none
module rdp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire rdp_pkg::rdp_cmd_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output rdp_pkg::rdp_cmd_t      rd_data
);
    import rdp_pkg::*;
    rdp_cmd_t mem_reg [QUEUE_DEPTH];
    logic     wp_reg, rp_reg;
    logic [1:0] fill_reg;
    logic     wr_en, rd_en;

    assign wr_ready = (fill_reg != 2'(QUEUE_DEPTH));
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid & wr_ready;
    assign rd_en    = rd_valid & rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            fill_reg <= fill_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule : rdp_queue
`default_nettype wire

// ===== sv/rdp_back.sv =====
// Simplifier: point memory, segment stack, farthest-point scan and output walk.
`default_nettype none
module rdp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [15:0]       tolerance,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire rdp_pkg::rdp_cmd_t cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [15:0]            kept_x,
    output logic [15:0]            kept_y,
    output logic                   last_kept,
    output logic [1:0]             status
);
    import rdp_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_RDS, S_RDE, S_CHORD, S_SCAN, S_SWAIT, S_MUL1, S_MUL2,
        S_TEST, S_EMIT_RD, S_EMIT, S_SHORT
    } state_t;

    state_t state_reg;
    logic [31:0]      mem [MAX_POINTS];
    logic             keep_mem [MAX_POINTS];
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_data_reg;
    logic             keep_rd_reg;
    logic [2*IDX_W-1:0] stk [MAX_POINTS];
    logic [CNT_W-1:0] sp_reg;
    logic [CNT_W-1:0] n_reg;
    logic             ovf_reg;
    logic [IDX_W-1:0] s_reg, e_reg, i_reg, best_idx_reg, pend_reg;
    logic             pend_v_reg;
    logic signed [15:0] xs_reg, ys_reg;
    logic signed [16:0] ex_reg, ey_reg;
    logic [33:0]      chord2_reg;
    logic [33:0]      best_reg;
    logic             found_reg;
    logic [67:0]      lhs_reg;
    logic [65:0]      rhs_reg;
    logic [31:0]      eps2_reg;
    logic [15:0]      ox_reg, oy_reg;
    logic             olast_reg;
    logic [1:0]       ost_reg;
    logic             ov_reg;
    logic [2*IDX_W-1:0] stk_top_reg;
    logic             split;
    logic             emit_keep;
    logic             ov_load;

    // scan datapath (one point a cycle, from registered memory data)
    logic signed [16:0] qx, qy;
    logic signed [34:0] crs;
    logic [33:0] dval;
    logic [33:0] qx2, qy2;
    always_comb
    begin
        qx   = 17'(signed'(rd_data_reg[31:16])) - 17'(xs_reg);
        qy   = 17'(signed'(rd_data_reg[15:0]))  - 17'(ys_reg);
        crs  = 35'(ex_reg * qy) - 35'(ey_reg * qx);
        qx2  = 34'(qx * qx);
        qy2  = 34'(qy * qy);
        dval = (chord2_reg == '0) ? qx2 + qy2
             : (crs[34] ? 34'(-crs) : 34'(crs));
    end

    // endpoints always kept; interior marks come from the keep memory
    assign split     = found_reg && (lhs_reg > 68'(rhs_reg));
    assign emit_keep = keep_rd_reg || (i_reg == '0) || (CNT_W'(i_reg) == n_reg - 1'b1);
    assign ov_load   = ((state_reg == S_SHORT) && !ov_reg)
                     || ((state_reg == S_EMIT) && (!ov_reg || out_ready) && emit_keep);

    assign cmd_ready = (state_reg == S_LOAD);
    assign out_valid = ov_reg;
    assign kept_x    = ox_reg;
    assign kept_y    = oy_reg;
    assign last_kept = olast_reg;
    assign status    = ost_reg;

    always_comb
    begin
        rd_addr = i_reg;
        unique case (state_reg)
            S_RDS:   rd_addr = s_reg;
            S_RDE:   rd_addr = e_reg;
            default: rd_addr = i_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && cmd.is_point)
        begin
            mem[cmd.slot]      <= {cmd.x, cmd.y};
            keep_mem[cmd.slot] <= 1'b0;
        end
        rd_data_reg <= mem[rd_addr];
        keep_rd_reg <= keep_mem[rd_addr];
        stk_top_reg <= stk[sp_reg[IDX_W-1:0] - 1'b1];
        if (state_reg == S_TEST && split)
        begin
            keep_mem[best_idx_reg] <= 1'b1;
            stk[sp_reg[IDX_W-1:0]] <= {s_reg, best_idx_reg};
        end
        if (state_reg == S_POP && pend_v_reg)
            stk[sp_reg[IDX_W-1:0]] <= {pend_reg, e_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && !ov_load) ov_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                    if (cmd_valid && cmd_ready && cmd.end_line)
                    begin
                        n_reg    <= cmd.count;
                        ovf_reg  <= cmd.overflow;
                        eps2_reg <= 32'(tolerance) * 32'(tolerance);
                        sp_reg   <= '0;
                        if (cmd.count < CNT_W'(2))
                            state_reg <= S_SHORT;
                        else if (cmd.count < CNT_W'(3))
                        begin
                            // two points: no interior, straight to output
                            i_reg     <= '0;
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            s_reg  <= '0;
                            e_reg  <= IDX_W'(cmd.count - 1'b1);
                            state_reg <= S_RDS;
                        end
                    end
                S_SHORT:
                    if (!ov_reg)
                    begin
                        ov_reg    <= 1'b1;
                        ox_reg    <= '0;
                        oy_reg    <= '0;
                        olast_reg <= 1'b1;
                        ost_reg   <= ovf_reg ? ST_OVERFLOW : ST_TOO_FEW;
                        state_reg <= S_LOAD;
                    end
                S_POP:
                    // second half of a split goes on the stack last, so it is popped first
                    if (pend_v_reg)
                    begin
                        pend_v_reg <= 1'b0;
                        sp_reg     <= sp_reg + 1'b1;
                    end
                    else if (sp_reg == '0)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        state_reg <= S_SWAIT; // stk_top_reg valid next cycle
                    end
                S_SWAIT:
                begin
                    s_reg <= stk_top_reg[2*IDX_W-1:IDX_W];
                    e_reg <= stk_top_reg[IDX_W-1:0];
                    if (CNT_W'(stk_top_reg[IDX_W-1:0])
                            < CNT_W'(stk_top_reg[2*IDX_W-1:IDX_W]) + CNT_W'(2)
                        || CNT_W'(stk_top_reg[IDX_W-1:0]) >= n_reg)
                        state_reg <= S_POP;
                    else
                        state_reg <= S_RDS;
                end
                S_RDS:  state_reg <= S_RDE;
                S_RDE:
                begin
                    xs_reg    <= signed'(rd_data_reg[31:16]);
                    ys_reg    <= signed'(rd_data_reg[15:0]);
                    i_reg     <= s_reg + 1'b1;
                    state_reg <= S_CHORD;
                end
                S_CHORD:
                begin
                    ex_reg     <= 17'(signed'(rd_data_reg[31:16])) - 17'(xs_reg);
                    ey_reg     <= 17'(signed'(rd_data_reg[15:0])) - 17'(ys_reg);
                    best_reg   <= '0;
                    found_reg  <= 1'b0;
                    i_reg      <= s_reg + 1'b1;
                    state_reg  <= S_MUL1;
                end
                S_MUL1:
                begin
                    chord2_reg <= 34'(ex_reg * ex_reg) + 34'(ey_reg * ey_reg);
                    i_reg      <= i_reg + 1'b1;   // read of s+1 issued this cycle
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    // rd_data_reg holds point i_reg-1
                    if (dval > best_reg)
                    begin
                        best_reg     <= dval;
                        best_idx_reg <= i_reg - 1'b1;
                        found_reg    <= 1'b1;
                    end
                    if (i_reg == e_reg)
                        state_reg <= S_MUL2;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_MUL2:
                begin
                    if (chord2_reg == '0)
                    begin
                        lhs_reg <= 68'(best_reg);
                        rhs_reg <= 66'(eps2_reg);
                    end
                    else
                    begin
                        lhs_reg <= best_reg * best_reg;
                        rhs_reg <= eps2_reg * chord2_reg;
                    end
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (split)
                    begin
                        sp_reg     <= sp_reg + 1'b1;
                        pend_reg   <= best_idx_reg;
                        pend_v_reg <= 1'b1;
                    end
                    state_reg <= S_POP;
                end
                S_EMIT_RD: state_reg <= S_EMIT;
                S_EMIT:
                    if (!ov_reg || out_ready)
                    begin
                        if (emit_keep)
                        begin
                            ov_reg    <= 1'b1;
                            ox_reg    <= rd_data_reg[31:16];
                            oy_reg    <= rd_data_reg[15:0];
                            olast_reg <= (CNT_W'(i_reg) == n_reg - 1'b1);
                            ost_reg   <= ovf_reg ? ST_OVERFLOW : ST_OK;
                        end
                        if (CNT_W'(i_reg) == n_reg - 1'b1)
                            state_reg <= S_LOAD;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule : rdp_back
`default_nettype wire

// ===== sv/rdp_checker.sv =====
// Port-level checks for the simplifier, bound to the top level.
`default_nettype none
module rdp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        last_kept,
    input wire logic [1:0]  status,
    input wire logic [15:0] kept_x,
    input wire logic        pready
);
    import rdp_pkg::*;
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");
    a_toofew: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TOO_FEW |-> last_kept && kept_x == '0)
        else $error("too-few result malformed");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kept_x))
        else $error("output dropped");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule : rdp_checker
bind polyline_simplify_rdp_unit rdp_checker u_chk (
    .clk, .rst_n, .out_valid, .out_ready, .last_kept, .status, .kept_x, .pready
);
`default_nettype wire

// ===== bench/polyline_simplify_rdp_unit_test.sv =====
// Testbench for the RDP polyline simplifier: random and directed polylines checked against a predictor.
`default_nettype none
module polyline_simplify_rdp_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rdp_pkg::*;

    localparam logic [0:0] ADDR_TOLERANCE = 1'b0;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        logic [1:0]  status;
    } kept_point_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        end_of_line;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] kept_x;
    logic [15:0] kept_y;
    logic        last_kept;
    logic [1:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: its own copy of the line being loaded and the tolerance.
    logic [15:0] line_x [MAX_POINTS];
    logic [15:0] line_y [MAX_POINTS];
    int          line_len;
    bit          line_dropped;
    logic [15:0] eps;

    kept_point_t expected_kept[$];
    int          fail_count;
    int          idle_cycles;
    int          lines_sent;
    int          words_sent;
    int          words_seen;
    bit          stall_free;

    polyline_simplify_rdp_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .end_of_line(end_of_line),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kept_x     (kept_x),
        .kept_y     (kept_y),
        .last_kept  (last_kept),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none at all when stall_free.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (stall_free) return 0;
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Simplifies the stored line with a segment stack and queues kept points.
    task automatic predict_line();
        bit          keep [MAX_POINTS];
        int          seg_s[$];
        int          seg_e[$];
        int          s, e, n, idx;
        longint      xs, ys, ex, ey, qx, qy, d, best;
        logic [127:0] lhs, rhs, chord2;
        kept_point_t kp;
        n = line_len;
        if (n < 2)
        begin
            kp = '{x: 16'd0, y: 16'd0, last: 1'b1,
                   status: line_dropped ? ST_OVERFLOW : ST_TOO_FEW};
            expected_kept.insert(expected_kept.size(), kp);
        end
        else
        begin
            foreach (keep[i]) keep[i] = 1'b0;
            keep[0] = 1'b1;
            keep[n-1] = 1'b1;
            seg_s.insert(seg_s.size(), 0);
            seg_e.insert(seg_e.size(), n - 1);
            while (seg_s.size() > 0)
            begin
                s = seg_s.pop_back();
                e = seg_e.pop_back();
                if (e < s + 2) continue;
                xs = longint'($signed(line_x[s]));
                ys = longint'($signed(line_y[s]));
                ex = longint'($signed(line_x[e])) - xs;
                ey = longint'($signed(line_y[e])) - ys;
                chord2 = ex * ex + ey * ey;
                best = 0;
                idx = -1;
                for (int i = s + 1; i < e; i++)
                begin
                    qx = longint'($signed(line_x[i])) - xs;
                    qy = longint'($signed(line_y[i])) - ys;
                    if (chord2 == 0) d = qx * qx + qy * qy;
                    else
                    begin
                        d = ex * qy - ey * qx;
                        if (d < 0) d = -d;
                    end
                    if (d > best)
                    begin
                        best = d;
                        idx = i;
                    end
                end
                if (idx < 0) continue;
                lhs = (chord2 == 0) ? 128'(best) : 128'(best) * 128'(best);
                rhs = 128'(eps) * 128'(eps);
                if (chord2 != 0) rhs = rhs * chord2;
                if (lhs > rhs)
                begin
                    keep[idx] = 1'b1;
                    seg_s.insert(seg_s.size(), s);
                    seg_e.insert(seg_e.size(), idx);
                    seg_s.insert(seg_s.size(), idx);
                    seg_e.insert(seg_e.size(), e);
                end
            end
            for (int i = 0; i < n; i++)
            begin
                if (!keep[i]) continue;
                kp = '{x: line_x[i], y: line_y[i], last: (i == n - 1),
                       status: line_dropped ? ST_OVERFLOW : ST_OK};
                expected_kept.insert(expected_kept.size(), kp);
            end
        end
        line_len = 0;
        line_dropped = 1'b0;
    endtask

    // Sends one word and updates the predictor once the handshake completes.
    // in_valid stays high after the handshake so words can follow back to back;
    // a gap or drain() drops it.
    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic eol);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        end_of_line <= eol;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (line_len < MAX_POINTS)
        begin
            line_x[line_len] = x;
            line_y[line_len] = y;
            line_len++;
        end
        else line_dropped = 1'b1;
        if (eol)
        begin
            predict_line();
            lines_sent++;
        end
    endtask

    task automatic send_line(input int n, input int spread);
        for (int i = 0; i < n; i++)
            send_point(16'($urandom_range(0, 2*spread) - spread),
                       16'($urandom_range(0, 2*spread) - spread), i == n - 1);
    endtask

    // Waits for every expected point to drain, then a margin for trailing work.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_kept.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOLERANCE;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eps = value;
    endtask

    // Receiver: random stalls on out_ready, compares each word with the oldest expectation.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                kept_point_t want;
                words_seen++;
                if (expected_kept.size() == 0)
                begin
                    $error("unexpected word x=%h y=%h", kept_x, kept_y);
                    fail_count++;
                end
                else
                begin
                    want = expected_kept.pop_front();
                    if (kept_x !== want.x)
                    begin
                        $error("kept_x expected %h got %h", want.x, kept_x);
                        fail_count++;
                    end
                    if (kept_y !== want.y)
                    begin
                        $error("kept_y expected %h got %h", want.y, kept_y);
                        fail_count++;
                    end
                    if (last_kept !== want.last)
                    begin
                        $error("last_kept expected %b got %b", want.last, last_kept);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, status);
                        fail_count++;
                    end
                end
            end
            out_ready <= (stall_free || $urandom_range(0, 3) != 0) ? 1'b1
                       : ($urandom_range(0, 9) == 0 ? 1'b0 : out_ready);
        end
    end

    // Watchdog: counts cycles with no word moving on either side.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d points outstanding", expected_kept.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic test_short_lines();
        send_point(16'h0001, 16'h0002, 1'b1);     // single point: too few
        send_point(16'h7FFF, 16'h8000, 1'b0);     // two points: both ends kept
        send_point(16'h8000, 16'h7FFF, 1'b1);
    endtask

    task automatic test_extremes();
        // Zero-length chord with interior excursions to the coordinate limits.
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        // Long diagonal chord, points on and off the line, ties on distance.
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b0);
        send_point(16'h0010, 16'hFFF0, 1'b0);
        send_point(16'hFFF0, 16'h0010, 1'b0);
        send_point(16'h7FFF, 16'h7FFF, 1'b1);
        // Collinear points: all interior points dropped.
        for (int i = 0; i < 5; i++) send_point(16'(i * 3), 16'(i * 5), i == 4);
    endtask

    task automatic test_overflow();
        send_line(MAX_POINTS + 3, 300);
        for (int i = 0; i < MAX_POINTS; i++)
            send_point(16'(i), 16'(i * i), 1'b0);
        send_point(16'h1234, 16'h4321, 1'b1);     // end marker on a dropped point
        send_line(MAX_POINTS, 20);                // exactly full, no drop
    endtask

    task automatic test_random(input int budget, input int spread);
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            int n;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAX_POINTS + 2)
                                             : $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0)
            begin
                for (int i = 0; i < n; i++)
                    send_point(16'($urandom), 16'($urandom), i == n - 1);
            end
            else send_line(n, spread);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        end_of_line = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        eps = '0;
        line_len = 0;
        line_dropped = 1'b0;
        fail_count = 0;
        lines_sent = 0;
        words_sent = 0;
        words_seen = 0;
        stall_free = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tolerance zero: every off-chord point survives.
        test_short_lines();
        test_extremes();
        drain();
        write_tolerance(16'd5);
        test_overflow();
        drain();
        write_tolerance(16'hFFFF);
        test_extremes();
        test_random(60, 32768);
        drain();
        write_tolerance(16'd40);
        stall_free = 1'b1;
        test_random(60, 200);
        stall_free = 1'b0;
        test_random(100, 200);
        drain();
        write_tolerance(16'd1);
        test_random(60, 60);
        drain();

        $display("Sent %0d points in %0d lines; checked %0d kept points over five tolerance settings.",
                 words_sent, lines_sent, words_seen);
        if (fail_count == 0 && expected_kept.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
